[rtl/core/clcd_pkg.sv]
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, codes and start-up tables for the character-LCD nibble
// sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

	typedef enum logic [2:0] {
		ACT_INIT  = 3'd0,
		ACT_CHAR  = 3'd1,
		ACT_CLEAR = 3'd2,
		ACT_MOVE  = 3'd3,
		ACT_RAW   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		CFG_CHAR_DELAY  = 2'd0,
		CFG_CLEAR_DELAY = 2'd1,
		CFG_POWER_DELAY = 2'd2
	} cfg_index_t;

	localparam logic [15:0] CHAR_DELAY_RST  = 16'd50;
	localparam logic [15:0] CLEAR_DELAY_RST = 16'd1640;
	localparam logic [15:0] POWER_DELAY_RST = 16'd20000;

	localparam logic [7:0] CMD_CLEAR     = 8'h01;
	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

	// power-up wait is step 0, start-up nibbles are steps 1..14
	localparam logic [3:0] INIT_LAST_STEP = 4'd14;
	localparam logic [3:0] BYTE_LAST_STEP = 4'd1;

	// one queued command: a byte to send or the whole start-up sequence
	typedef struct packed {
		logic        is_init;
		logic [7:0]  data;
		logic        rs;
		logic [15:0] wait_us;
	} cmd_t;

	function automatic logic [3:0] init_nibble(input logic [3:0] idx);
		logic [3:0] n;
		case (idx)
			4'd0, 4'd1, 4'd2: n = 4'h3;
			4'd3, 4'd4:       n = 4'h2;
			4'd5, 4'd7:       n = 4'h8;
			4'd9:             n = 4'h1;
			4'd11:            n = 4'h6;
			4'd13:            n = 4'hC;
			default:          n = 4'h0;
		endcase
		return n;
	endfunction

	function automatic logic [15:0] init_wait(input logic [3:0] idx);
		logic [15:0] w;
		case (idx)
			4'd0:                   w = 16'd4100;
			4'd1, 4'd2, 4'd3:       w = 16'd100;
			4'd8, 4'd9:             w = 16'd1500;
			default:                w = 16'd40;
		endcase
		return w;
	endfunction

endpackage

[rtl/core/clcd_front.sv]
// ----------------------------------------------------------------------------
// clcd_front
// Holds the delay registers, decodes each request into a queued command
// (byte, rs, wait or start-up sequence) and drops unused action codes.
// ----------------------------------------------------------------------------
module clcd_front
	import clcd_pkg::*;
#(
	parameter int LINE_OFFSET = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [7:0]  data_byte,
	input  logic        rs_select,
	input  logic [15:0] delay_us,
	input  logic [5:0]  column,
	input  logic [1:0]  row,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        q_full,
	output logic        push,
	output cmd_t        push_cmd
);

	localparam logic [7:0] LINE_OFF8 = 8'(LINE_OFFSET);

	logic [15:0] char_delay_q;
	logic [15:0] clear_delay_q;
	logic [15:0] power_delay_q;

	logic [7:0]  row_m1;
	logic [7:0]  line_prod;
	logic [7:0]  move_addr;
	logic        known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_delay_q  <= CHAR_DELAY_RST;
			clear_delay_q <= CLEAR_DELAY_RST;
			power_delay_q <= POWER_DELAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_CHAR_DELAY:  char_delay_q  <= cfg_data;
				CFG_CLEAR_DELAY: clear_delay_q <= cfg_data;
				CFG_POWER_DELAY: power_delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ddram address wraps modulo 256, also for out-of-range row or column
	assign row_m1    = {6'b0, row} - 8'd1;
	assign line_prod = row_m1 * LINE_OFF8;
	assign move_addr = CMD_SET_DDRAM + line_prod + ({2'b0, column} - 8'd1);

	always_comb begin
		known            = 1'b1;
		push_cmd.is_init = 1'b0;
		push_cmd.data    = data_byte;
		push_cmd.rs      = 1'b0;
		push_cmd.wait_us = char_delay_q;
		unique case (action_t'(action))
			ACT_INIT: begin
				push_cmd.is_init = 1'b1;
				push_cmd.wait_us = power_delay_q;
			end
			ACT_CHAR: begin
				push_cmd.rs = 1'b1;
			end
			ACT_CLEAR: begin
				push_cmd.data    = CMD_CLEAR;
				push_cmd.wait_us = clear_delay_q;
			end
			ACT_MOVE: begin
				push_cmd.data = move_addr;
			end
			ACT_RAW: begin
				push_cmd.rs      = rs_select;
				push_cmd.wait_us = delay_us;
			end
			default: known = 1'b0;
		endcase
	end

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full && known;

endmodule

[rtl/core/clcd_queue.sv]
// ----------------------------------------------------------------------------
// clcd_queue
// Two-entry command queue between the decode front and the nibble back end.
// ----------------------------------------------------------------------------
module clcd_queue
	import clcd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign full       = count_q[1];
	assign head_valid = count_q != 2'd0;
	assign head_cmd   = mem_q[rd_ptr_q];

endmodule

[rtl/core/clcd_back.sv]
// ----------------------------------------------------------------------------
// clcd_back
// Walks the head command nibble by nibble into a registered result stage,
// one result per cycle while the output side takes them.
// ----------------------------------------------------------------------------
module clcd_back
	import clcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  cmd_t        head_cmd,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  nibble,
	output logic        reg_select,
	output logic        strobe_res,
	output logic [15:0] wait_us,
	output logic        last
);

	logic [3:0]  step_q;
	logic        out_valid_q;
	logic [3:0]  nibble_q;
	logic        reg_select_q;
	logic        strobe_q;
	logic [15:0] wait_q;
	logic        last_q;

	logic        load;
	logic        last_step;
	logic [3:0]  nxt_nibble;
	logic        nxt_rs;
	logic        nxt_strobe;
	logic [15:0] nxt_wait;

	assign load      = head_valid && (!out_valid_q || out_ready);
	assign last_step = head_cmd.is_init ? (step_q == INIT_LAST_STEP)
	                                    : (step_q == BYTE_LAST_STEP);
	assign pop       = load && last_step;

	always_comb begin
		nxt_rs     = head_cmd.rs;
		nxt_strobe = 1'b1;
		nxt_wait   = head_cmd.wait_us;
		if (head_cmd.is_init) begin
			nxt_rs = 1'b0;
			if (step_q == 4'd0) begin
				// power-up wait, no enable pulse
				nxt_nibble = 4'h0;
				nxt_strobe = 1'b0;
			end else begin
				nxt_nibble = init_nibble(step_q - 4'd1);
				nxt_wait   = init_wait(step_q - 4'd1);
			end
		end else begin
			nxt_nibble = (step_q == 4'd0) ? head_cmd.data[7:4] : head_cmd.data[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= last_step ? 4'd0 : step_q + 4'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			nibble_q     <= nxt_nibble;
			reg_select_q <= nxt_rs;
			strobe_q     <= nxt_strobe;
			wait_q       <= nxt_wait;
			last_q       <= last_step;
		end
	end

	assign out_valid  = out_valid_q;
	assign nibble     = nibble_q;
	assign reg_select = reg_select_q;
	assign strobe_res = strobe_q;
	assign wait_us    = wait_q;
	assign last       = last_q;

endmodule

[rtl/core/char_lcd_nibble_sequencer.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Turns character-LCD requests into 4-bit nibble strobe results.
// ----------------------------------------------------------------------------
// path: an accepted request goes into the command queue, then its first result into the back
//   end's output register, when the queue is empty and the output stage is free
// throughput: one result per cycle while the output side takes them and a command waits;
//   print, clear, move and raw give 2 results each, init gives 15
// two-entry command queue lets requests be taken while results still wait
// reset: queue and output stage empty, delay registers at 50 / 1640 / 20000
module char_lcd_nibble_sequencer
	import clcd_pkg::*;
#(
	parameter int LINE_OFFSET = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [7:0]  data_byte,
	input  logic        rs_select,
	input  logic [15:0] delay_us,
	input  logic [5:0]  column,
	input  logic [1:0]  row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  nibble,
	output logic        reg_select,
	output logic        strobe_res,
	output logic [15:0] wait_us,
	output logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	clcd_front #(
		.LINE_OFFSET(LINE_OFFSET)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.data_byte(data_byte),
		.rs_select(rs_select),
		.delay_us (delay_us),
		.column   (column),
		.row      (row),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	clcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (q_full),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	clcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.nibble    (nibble),
		.reg_select(reg_select),
		.strobe_res(strobe_res),
		.wait_us   (wait_us),
		.last      (last)
	);

	// a command only leaves the queue once it is there
	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	// no request lands in a full queue
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("request pushed into full queue");

	// the wait-only power-up result never ends a request and drives no data
	a_powerup_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !strobe_res) |-> (!last && nibble == 4'h0 && !reg_select))
		else $error("malformed wait-only result");

	// a popped command leaves a final result in the output stage
	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid && last))
		else $error("command retired without a final result");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer testbench
// Sends LCD requests (init, print, clear, move, raw, unused codes) through the
// valid/ready request channel and checks every nibble strobe against a local
// model of the sequencer. The delay registers are changed between phases.
// Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
	import clcd_pkg::*;

	localparam int LINE_OFFSET  = 64;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 85;

	// start-up nibbles and their waits, first entry in the top bits
	localparam logic [55:0]  START_NIBS  = 56'h3332280801060C;
	localparam logic [223:0] START_WAITS = {16'd4100, 16'd100, 16'd100, 16'd100,
		16'd40, 16'd40, 16'd40, 16'd40, 16'd1500, 16'd1500, 16'd40, 16'd40,
		16'd40, 16'd40};

	typedef struct packed {
		logic [3:0]  nib;
		logic        rs;
		logic        pulse;
		logic [15:0] hold_us;
		logic        fin;
	} strobe_t;

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [2:0]  action     = '0;
	logic [7:0]  data_byte  = '0;
	logic        rs_select  = 1'b0;
	logic [15:0] delay_us   = '0;
	logic [5:0]  column     = '0;
	logic [1:0]  row        = '0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [3:0]  nibble;
	logic        reg_select;
	logic        strobe_res;
	logic [15:0] wait_us;
	logic        last;
	logic        cfg_we     = 1'b0;
	logic [1:0]  cfg_index  = '0;
	logic [15:0] cfg_data   = '0;

	strobe_t     pending_strobes[$];
	strobe_t     want_strobe;
	strobe_t     got_strobe;
	logic [15:0] char_delay  = CHAR_DELAY_RST;
	logic [15:0] clear_delay = CLEAR_DELAY_RST;
	logic [15:0] power_delay = POWER_DELAY_RST;
	int          error_count = 0;
	int          cycle_count = 0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;

	char_lcd_nibble_sequencer #(
		.LINE_OFFSET(LINE_OFFSET)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.data_byte(data_byte),
		.rs_select(rs_select),
		.delay_us(delay_us),
		.column(column),
		.row(row),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.nibble(nibble),
		.reg_select(reg_select),
		.strobe_res(strobe_res),
		.wait_us(wait_us),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// queue both nibbles of one byte, high nibble first
	task automatic push_byte(input logic [7:0] b, input logic r, input logic [15:0] w);
		pending_strobes.push_back('{nib: b[7:4], rs: r, pulse: 1'b1, hold_us: w, fin: 1'b0});
		pending_strobes.push_back('{nib: b[3:0], rs: r, pulse: 1'b1, hold_us: w, fin: 1'b1});
	endtask

	task automatic predict_strobes(input logic [2:0] act, input logic [7:0] d,
			input logic r, input logic [15:0] dl, input logic [5:0] c, input logic [1:0] rw);
		int addr;
		case (act)
			ACT_INIT: begin
				pending_strobes.push_back('{nib: 4'h0, rs: 1'b0, pulse: 1'b0,
					hold_us: power_delay, fin: 1'b0});
				for (int i = 0; i < 14; i++)
					pending_strobes.push_back('{nib: START_NIBS[55-4*i -: 4], rs: 1'b0,
						pulse: 1'b1, hold_us: START_WAITS[223-16*i -: 16], fin: (i == 13)});
			end
			ACT_CHAR:  push_byte(d, 1'b1, char_delay);
			ACT_CLEAR: push_byte(CMD_CLEAR, 1'b0, clear_delay);
			ACT_MOVE: begin
				// wraps modulo 256 for row or column zero / out of range
				addr = int'(CMD_SET_DDRAM) + (int'(rw) - 1) * LINE_OFFSET + int'(c) - 1;
				push_byte(addr[7:0], 1'b0, char_delay);
			end
			ACT_RAW:   push_byte(d, r, dl);
			default: ;
		endcase
	endtask

	task automatic send_request(input logic [2:0] act, input logic [7:0] d, input logic r,
			input logic [15:0] dl, input logic [5:0] c, input logic [1:0] rw);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= act;
		data_byte <= d;
		rs_select <= r;
		delay_us  <= dl;
		column    <= c;
		row       <= rw;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_strobes(act, d, r, dl, c, rw);
	endtask

	// unused actions leave nothing queued, so let the pipe settle too
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_strobes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_index_t idx, input logic [15:0] val);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CHAR_DELAY:  char_delay  = val;
			CFG_CLEAR_DELAY: clear_delay = val;
			CFG_POWER_DELAY: power_delay = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(input logic [15:0] cv, input logic [15:0] kv,
			input logic [15:0] pv);
		write_register(CFG_CHAR_DELAY, cv);
		write_register(CFG_CLEAR_DELAY, kv);
		write_register(CFG_POWER_DELAY, pv);
	endtask

	task automatic test_reset_defaults();
		send_request(ACT_INIT, 8'h00, 1'b0, 16'h0000, 6'd1, 2'd1);
		send_request(ACT_CHAR, 8'h41, 1'b0, 16'h0000, 6'd1, 2'd1);
		send_request(ACT_CLEAR, 8'hFF, 1'b1, 16'hFFFF, 6'd0, 2'd0);
		send_request(ACT_MOVE, 8'h00, 1'b0, 16'h0000, 6'd1, 2'd1);
	endtask

	task automatic test_field_extremes();
		send_request(ACT_CHAR, 8'h00, 1'b1, 16'hFFFF, 6'd63, 2'd3);
		send_request(ACT_CHAR, 8'hFF, 1'b0, 16'h0000, 6'd0, 2'd0);
		send_request(ACT_RAW, 8'hFF, 1'b1, 16'hFFFF, 6'd0, 2'd0);
		send_request(ACT_RAW, 8'h00, 1'b0, 16'h0000, 6'd63, 2'd3);
		send_request(ACT_MOVE, 8'hFF, 1'b1, 16'hFFFF, 6'd40, 2'd2);
		send_request(ACT_MOVE, 8'h00, 1'b0, 16'h0000, 6'd0, 2'd0);
		send_request(ACT_MOVE, 8'h00, 1'b0, 16'h0000, 6'd63, 2'd3);
		// unused codes must produce nothing
		send_request(3'd5, 8'hFF, 1'b1, 16'hFFFF, 6'd63, 2'd3);
		send_request(3'd6, 8'h55, 1'b0, 16'h1234, 6'd1, 2'd1);
		send_request(3'd7, 8'hAA, 1'b1, 16'h8000, 6'd40, 2'd2);
	endtask

	task automatic test_delay_extremes();
		write_all(16'h0000, 16'h0000, 16'h0000);
		send_request(ACT_INIT, 8'h00, 1'b0, 16'h0000, 6'd0, 2'd0);
		send_request(ACT_CHAR, 8'h7E, 1'b0, 16'hFFFF, 6'd0, 2'd0);
		send_request(ACT_CLEAR, 8'h00, 1'b0, 16'h0000, 6'd0, 2'd0);
		send_request(ACT_MOVE, 8'h00, 1'b0, 16'h0000, 6'd20, 2'd2);
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(ACT_INIT, 8'h00, 1'b0, 16'h0000, 6'd0, 2'd0);
		send_request(ACT_CLEAR, 8'h00, 1'b0, 16'h0000, 6'd0, 2'd0);
		send_request(ACT_MOVE, 8'h00, 1'b0, 16'h0000, 6'd40, 2'd1);
	endtask

	function automatic logic [15:0] pick_delay();
		case ($urandom_range(3))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_random_traffic();
		int idle_plan[4]  = '{0, 45, 0, 27};
		int stall_plan[4] = '{0, 0, 45, 27};
		int sent;
		int pick;
		logic [2:0] act;
		logic [5:0] c;
		logic [1:0] rw;
		for (int ph = 0; ph < 4; ph++) begin
			write_all(pick_delay(), pick_delay(), pick_delay());
			send_idle_pct  = idle_plan[ph];
			recv_stall_pct = stall_plan[ph];
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 6)       act = ACT_INIT;
				else if (pick < 36) act = ACT_CHAR;
				else if (pick < 46) act = ACT_CLEAR;
				else if (pick < 66) act = ACT_MOVE;
				else if (pick < 92) act = ACT_RAW;
				else                act = 3'($urandom_range(7, 5));
				// mostly on-screen cursor positions, some wrapping ones
				if ($urandom_range(99) < 85) begin
					c  = 6'($urandom_range(40, 1));
					rw = 2'($urandom_range(2, 1));
				end else begin
					c  = 6'($urandom);
					rw = 2'($urandom);
				end
				send_request(act, 8'($urandom), 1'($urandom), 16'($urandom), c, rw);
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_strobe = '{nib: nibble, rs: reg_select, pulse: strobe_res,
				hold_us: wait_us, fin: last};
			if (pending_strobes.size() == 0) begin
				report_mismatch($sformatf("unexpected strobe nib=%h rs=%b en=%b wait=%0d last=%b",
					nibble, reg_select, strobe_res, wait_us, last));
			end else begin
				want_strobe = pending_strobes.pop_front();
				if (got_strobe !== want_strobe)
					report_mismatch($sformatf(
						"strobe got nib=%h rs=%b en=%b wait=%0d last=%b, exp nib=%h rs=%b en=%b wait=%0d last=%b",
						nibble, reg_select, strobe_res, wait_us, last,
						want_strobe.nib, want_strobe.rs, want_strobe.pulse,
						want_strobe.hold_us, want_strobe.fin));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("char_lcd_nibble_sequencer regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_field_extremes();
		test_delay_extremes();
		test_random_traffic();
		wait_idle();
		if (pending_strobes.size() != 0)
			report_mismatch($sformatf("%0d strobes never arrived", pending_strobes.size()));
		if (error_count == 0)
			$display("char_lcd_nibble_sequencer regression: pass");
		else
			$display("char_lcd_nibble_sequencer regression: fail");
		$finish;
	end

endmodule

[char_lcd_nibble_sequencer.f]
rtl/core/clcd_pkg.sv
rtl/core/clcd_front.sv
rtl/core/clcd_queue.sv
rtl/core/clcd_back.sv
rtl/core/char_lcd_nibble_sequencer.sv
tb/testbench.sv
